[design/llwd_pkg.sv]
// ----------------------------------------------------------------------------
// llwd_pkg: shared types for the least-loaded worker dispatcher
// Command and status codes, the request and response words, controller states.
// ----------------------------------------------------------------------------
package llwd_pkg;

   // Width of the slot number carried in the request and response words.
   localparam int SLOT_FIELD_BITS = 4;
   // Number of slots that the slot field can name.
   localparam int SLOT_FIELD_SPAN = 16;
   localparam int CAP_FIELD_BITS  = 8;
   localparam int LOAD_FIELD_BITS = 8;

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_REQUEST  = 2'd1,
      CMD_COMPLETE = 2'd2,
      CMD_DELETE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_ROOM    = 2'd1,
      STATUS_FULL       = 2'd2,
      STATUS_SLOT_INVAL = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic [SLOT_FIELD_BITS-1:0]  target_slot;
      logic [CAP_FIELD_BITS-1:0]   capacity;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [SLOT_FIELD_BITS-1:0]  chosen_slot;
      logic [LOAD_FIELD_BITS-1:0]  load;
   } rsp_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

[design/llwd_cell.sv]
// ----------------------------------------------------------------------------
// llwd_cell: one worker slot of the scan chain
// Holds the slot state, merges it into the passing search token, applies commits.
// ----------------------------------------------------------------------------
module llwd_cell #(
   parameter int INDEX      = 0,
   parameter int IDX_BITS   = 4,
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llwd_pkg::req_type     req_word,
   input  logic                  commit_en,
   input  logic [IDX_BITS-1:0]   commit_idx,
   input  logic                  tok_found_i,
   input  logic [IDX_BITS-1:0]   tok_idx_i,
   input  logic [COUNT_BITS-1:0] tok_active_i,
   output logic                  tok_found_o,
   output logic [IDX_BITS-1:0]   tok_idx_o,
   output logic [COUNT_BITS-1:0] tok_active_o
);

   localparam int CAP_WIDE = (COUNT_BITS > llwd_pkg::CAP_FIELD_BITS) ?
                             COUNT_BITS : llwd_pkg::CAP_FIELD_BITS;
   localparam logic [CAP_WIDE-1:0] COUNT_MAX_WIDE = CAP_WIDE'({COUNT_BITS{1'b1}});
   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);
   localparam logic [llwd_pkg::SLOT_FIELD_BITS-1:0] MY_FIELD =
      llwd_pkg::SLOT_FIELD_BITS'(INDEX);
   localparam bit NAMEABLE = (INDEX < llwd_pkg::SLOT_FIELD_SPAN);

   logic                  valid_ff, valid_in;
   logic [COUNT_BITS-1:0] cap_ff, cap_in;
   logic [COUNT_BITS-1:0] active_ff, active_in;
   logic                  found_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [COUNT_BITS-1:0] best_ff;

   logic                  has_room;
   logic                  target_hit;
   logic                  candidate;
   logic                  better;
   logic [CAP_WIDE-1:0]   cap_wide;
   logic [CAP_WIDE-1:0]   cap_sat;

   assign has_room   = valid_ff && (active_ff < cap_ff);
   assign target_hit = NAMEABLE && valid_ff && (req_word.target_slot == MY_FIELD);

   always_comb begin
      unique case (req_word.cmd)
         llwd_pkg::CMD_REGISTER: candidate = !valid_ff;
         llwd_pkg::CMD_REQUEST:  candidate = has_room;
         llwd_pkg::CMD_COMPLETE: candidate = target_hit;
         llwd_pkg::CMD_DELETE:   candidate = target_hit;
         default:                candidate = 1'b0;
      endcase
   end

   // First candidate wins, except a request that finds a strictly lower count.
   assign better = candidate &&
                   (!tok_found_i ||
                    ((req_word.cmd == llwd_pkg::CMD_REQUEST) && (active_ff < tok_active_i)));

   always_ff @(posedge clock) begin
      found_ff <= tok_found_i || candidate;
      idx_ff   <= better ? MY_IDX : tok_idx_i;
      best_ff  <= better ? active_ff : tok_active_i;
   end

   assign tok_found_o  = found_ff;
   assign tok_idx_o    = idx_ff;
   assign tok_active_o = best_ff;

   // Saturate the stored capacity to the count range.
   assign cap_wide = CAP_WIDE'(req_word.capacity);
   assign cap_sat  = (cap_wide > COUNT_MAX_WIDE) ? COUNT_MAX_WIDE : cap_wide;

   always_comb begin
      valid_in  = valid_ff;
      cap_in    = cap_ff;
      active_in = active_ff;
      if (commit_en && (commit_idx == MY_IDX)) begin
         unique case (req_word.cmd)
            llwd_pkg::CMD_REGISTER: begin
               valid_in  = 1'b1;
               cap_in    = COUNT_BITS'(cap_sat);
               active_in = '0;
            end
            llwd_pkg::CMD_REQUEST: begin
               active_in = active_ff + COUNT_BITS'(1);
            end
            llwd_pkg::CMD_COMPLETE: begin
               if (active_ff != '0) begin
                  active_in = active_ff - COUNT_BITS'(1);
               end
            end
            llwd_pkg::CMD_DELETE: begin
               valid_in = 1'b0;
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff    <= cap_in;
      active_ff <= active_in;
   end

endmodule

[design/llwd_ctrl.sv]
// ----------------------------------------------------------------------------
// llwd_ctrl: command sequencer and response register
// Holds the command word, times the chain scan, commits the pick, forms the reply.
// ----------------------------------------------------------------------------
module llwd_ctrl #(
   parameter int SLOTS      = 16,
   parameter int IDX_BITS   = 4,
   parameter int COUNT_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  llwd_pkg::req_type     req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output llwd_pkg::rsp_type     rsp_word,
   output llwd_pkg::req_type     cmd_word,
   output logic                  commit_en,
   output logic [IDX_BITS-1:0]   commit_idx,
   input  logic                  tok_found,
   input  logic [IDX_BITS-1:0]   tok_idx,
   input  logic [COUNT_BITS-1:0] tok_active
);

   localparam int CNT_BITS = $clog2(SLOTS + 1);
   localparam logic [CNT_BITS-1:0] SCAN_DONE = CNT_BITS'(SLOTS);
   localparam int IDX_WIDE = (IDX_BITS > llwd_pkg::SLOT_FIELD_BITS) ?
                             IDX_BITS : llwd_pkg::SLOT_FIELD_BITS;
   localparam int CNT_WIDE = (COUNT_BITS > llwd_pkg::LOAD_FIELD_BITS) ?
                             COUNT_BITS : llwd_pkg::LOAD_FIELD_BITS;

   llwd_pkg::state_type   state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   llwd_pkg::req_type     cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   llwd_pkg::rsp_type     rsp_ff, rsp_in;
   llwd_pkg::rsp_type     result;
   logic [IDX_WIDE-1:0]   idx_wide;
   logic [CNT_WIDE-1:0]   inc_wide;
   logic [CNT_WIDE-1:0]   dec_wide;
   logic                  out_free;

   assign idx_wide = IDX_WIDE'(tok_idx);
   assign inc_wide = CNT_WIDE'(tok_active + COUNT_BITS'(1));
   assign dec_wide = (tok_active == '0) ? '0 : CNT_WIDE'(tok_active - COUNT_BITS'(1));

   always_comb begin
      result = '{status: llwd_pkg::STATUS_OK, chosen_slot: '0, load: '0};
      unique case (cmd_ff.cmd)
         llwd_pkg::CMD_REGISTER: begin
            if (tok_found) begin
               result.chosen_slot = idx_wide[llwd_pkg::SLOT_FIELD_BITS-1:0];
            end else begin
               result.status = llwd_pkg::STATUS_FULL;
            end
         end
         llwd_pkg::CMD_REQUEST: begin
            if (tok_found) begin
               result.chosen_slot = idx_wide[llwd_pkg::SLOT_FIELD_BITS-1:0];
               result.load        = inc_wide[llwd_pkg::LOAD_FIELD_BITS-1:0];
            end else begin
               result.status = llwd_pkg::STATUS_NO_ROOM;
            end
         end
         llwd_pkg::CMD_COMPLETE: begin
            result.chosen_slot = cmd_ff.target_slot;
            if (tok_found) begin
               result.load = dec_wide[llwd_pkg::LOAD_FIELD_BITS-1:0];
            end else begin
               result.status = llwd_pkg::STATUS_SLOT_INVAL;
            end
         end
         llwd_pkg::CMD_DELETE: begin
            result.chosen_slot = cmd_ff.target_slot;
            if (!tok_found) begin
               result.status = llwd_pkg::STATUS_SLOT_INVAL;
            end
         end
         default: begin
            result.status = llwd_pkg::STATUS_OK;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      commit_en    = 1'b0;
      unique case (state_ff)
         llwd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_word;
               count_in = '0;
               state_in = llwd_pkg::ST_SCAN;
            end
         end
         llwd_pkg::ST_SCAN: begin
            if (count_ff != SCAN_DONE) begin
               count_in = count_ff + CNT_BITS'(1);
            end else if (out_free) begin
               // Token has left the last cell: commit and publish.
               commit_en    = tok_found;
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = llwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = llwd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= llwd_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign commit_idx = tok_idx;
   assign cmd_word   = cmd_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

[design/least_loaded_worker_dispatcher.sv]
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatcher: worker slot table with least-loaded pick
// A chain of slot cells scanned by a travelling search token, one cell a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_word carries a command (register, request, complete, delete), a
//   target slot and a capacity; rsp_word returns status, slot and load.
//   Both channels use valid/ready; a word moves when valid and ready are high.
//   Each command yields exactly one response word.
// Sequencing:
//   One command is handled at a time. After acceptance the search token walks
//   the SLOTS cells, one cell per cycle; the response is registered once the
//   token has left the last cell, and a new command is taken only after the
//   controller has returned to idle. The length of the cell chain sets how
//   long each command takes.
// Reset:
//   Synchronous, active high. All slots become free; no response is pending.
// Receiver stall:
//   The response sits in an output register. The next command is accepted and
//   scanned while it waits; its commit and response hold at the end of the
//   scan until the previous response is taken.
// ----------------------------------------------------------------------------
module least_loaded_worker_dispatcher #(
   parameter int SLOTS      = 16,
   parameter int COUNT_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  llwd_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output llwd_pkg::rsp_type rsp_word
);

   localparam int IDX_BITS = $clog2(SLOTS);

   llwd_pkg::req_type     cmd_word;
   logic                  commit_en;
   logic [IDX_BITS-1:0]   commit_idx;

   // Token links: entry k feeds cell k, entry SLOTS is the chain output.
   logic                  tok_found  [SLOTS+1];
   logic [IDX_BITS-1:0]   tok_idx    [SLOTS+1];
   logic [COUNT_BITS-1:0] tok_active [SLOTS+1];

   // Seed the chain with an empty token.
   assign tok_found[0]  = 1'b0;
   assign tok_idx[0]    = '0;
   assign tok_active[0] = '0;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      llwd_cell #(
         .INDEX      (k),
         .IDX_BITS   (IDX_BITS),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .req_word     (cmd_word),
         .commit_en    (commit_en),
         .commit_idx   (commit_idx),
         .tok_found_i  (tok_found[k]),
         .tok_idx_i    (tok_idx[k]),
         .tok_active_i (tok_active[k]),
         .tok_found_o  (tok_found[k+1]),
         .tok_idx_o    (tok_idx[k+1]),
         .tok_active_o (tok_active[k+1])
      );
   end

   // Sequence the scan, commit the winner, register the response.
   llwd_ctrl #(
      .SLOTS      (SLOTS),
      .IDX_BITS   (IDX_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .cmd_word   (cmd_word),
      .commit_en  (commit_en),
      .commit_idx (commit_idx),
      .tok_found  (tok_found[SLOTS]),
      .tok_idx    (tok_idx[SLOTS]),
      .tok_active (tok_active[SLOTS])
   );

endmodule

[design/llwd_checker.sv]
// ----------------------------------------------------------------------------
// llwd_checker: port-level checks for the dispatcher
// Response handshake, one command in flight, and response field consistency.
// ----------------------------------------------------------------------------
module llwd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input llwd_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input llwd_pkg::rsp_type rsp_word
);

   // Stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   // One command in flight: no acceptance right after an acceptance.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while one is in flight");

   // Any failing status carries zero load.
   a_fail_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != llwd_pkg::STATUS_OK) |-> rsp_word.load == '0)
      else $error("nonzero load on failing status");

   // No room and table full name no slot.
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_word.status == llwd_pkg::STATUS_NO_ROOM) ||
                    (rsp_word.status == llwd_pkg::STATUS_FULL))
      |-> rsp_word.chosen_slot == '0)
      else $error("slot given with no-room or full status");

endmodule

bind least_loaded_worker_dispatcher llwd_checker u_llwd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
